FILE: hw/rtl/assert_macros.svh
// assertion helpers, sampled on clk and held off while reset is asserted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/ccfd_pkg.sv
`default_nettype none
package ccfd_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int LIM_CAP_I = (MAX_FRAME_BYTES < 256) ? MAX_FRAME_BYTES : 256;
  localparam logic [8:0] LIM_CAP = 9'(LIM_CAP_I);
  localparam logic [8:0] CFG_RESET = 9'd256;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [7:0] CODE_MAX = 8'hFF;
  localparam logic [7:0] DELIM = 8'h00;
  localparam logic [2:0] DLY_FULL = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_COBS_ERR = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_CRC_ERR = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  typedef struct packed {
    logic       is_end;
    logic [7:0] pbyte;
    logic [2:0] status;
    logic [7:0] plen;
  } res_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ccfd_cobs_core.sv
`default_nettype none
`include "assert_macros.svh"
module ccfd_cobs_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      byte_i,
  input  wire logic [8:0]      lim_i,
  output logic                 has_res,
  output ccfd_pkg::res_t       res
);

  logic [7:0]  rem_r, rem_nxt;
  logic        cmax_r, cmax_nxt;
  logic        started_r, started_nxt;
  logic [7:0]  dly_r [4];
  logic [7:0]  dly_nxt [4];
  logic [2:0]  fill_r, fill_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;

  logic        push_en;
  logic [7:0]  push_val;
  logic [31:0] rx_crc;

  assign rx_crc = {dly_r[3], dly_r[2], dly_r[1], dly_r[0]};

  always_comb begin
    rem_nxt = rem_r;
    cmax_nxt = cmax_r;
    started_nxt = started_r;
    dly_nxt = dly_r;
    fill_nxt = fill_r;
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    has_res = 1'b0;
    res = '0;
    push_en = 1'b0;
    push_val = '0;
    if (byte_i == ccfd_pkg::DELIM) begin
      if (started_r) begin
        has_res = 1'b1;
        res.is_end = 1'b1;
        res.plen = (cnt_r >= 9'd4) ? 8'(cnt_r - 9'd4) : 8'd0;
        if (ovf_r) begin
          res.status = ccfd_pkg::ST_TOO_LONG;
        end else if (rem_r != 8'd0) begin
          res.status = ccfd_pkg::ST_COBS_ERR;
        end else if (cnt_r < 9'd4) begin
          res.status = ccfd_pkg::ST_SHORT;
        end else if (rx_crc == ~crc_r) begin
          res.status = ccfd_pkg::ST_OK;
        end else begin
          res.status = ccfd_pkg::ST_CRC_ERR;
        end
        rem_nxt = '0;
        cmax_nxt = 1'b0;
        started_nxt = 1'b0;
        fill_nxt = '0;
        crc_nxt = ccfd_pkg::CRC_INIT;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end else begin
      if (rem_r == 8'd0) begin
        // code byte: implied zero between blocks unless last code was 0xff
        push_en = started_r && !cmax_r;
        rem_nxt = byte_i - 8'd1;
        cmax_nxt = (byte_i == ccfd_pkg::CODE_MAX);
      end else begin
        push_en = 1'b1;
        push_val = byte_i;
        rem_nxt = rem_r - 8'd1;
      end
      started_nxt = 1'b1;
      if (push_en && !ovf_r) begin
        if (cnt_r >= lim_i) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 9'd1;
          if (fill_r == ccfd_pkg::DLY_FULL) begin
            has_res = 1'b1;
            res.pbyte = dly_r[0];
            crc_nxt = ccfd_pkg::crc_byte(crc_r, dly_r[0]);
            dly_nxt[0] = dly_r[1];
            dly_nxt[1] = dly_r[2];
            dly_nxt[2] = dly_r[3];
            dly_nxt[3] = push_val;
          end else begin
            dly_nxt[fill_r[1:0]] = push_val;
            fill_nxt = fill_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cmax_r <= 1'b0;
      started_r <= 1'b0;
      fill_r <= '0;
      crc_r <= ccfd_pkg::CRC_INIT;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (fire) begin
      rem_r <= rem_nxt;
      cmax_r <= cmax_nxt;
      started_r <= started_nxt;
      fill_r <= fill_nxt;
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dly_r <= dly_nxt;
    end
  end

  `ASSERT_NEVER(a_fill_range, fill_r > ccfd_pkg::DLY_FULL, "delay line fill beyond four")
  `ASSERT_NEVER(a_cnt_range, cnt_r > ccfd_pkg::LIM_CAP, "decoded count beyond cap")
  `ASSERT_CHK(a_pay_full, (fire && has_res && !res.is_end) |-> (fill_r == ccfd_pkg::DLY_FULL), "payload left a partly filled delay line")
  `ASSERT_CHK(a_end_clear, (fire && byte_i == ccfd_pkg::DELIM) |=> (cnt_r == 9'd0 && !started_r), "frame state not cleared at delimiter")

endmodule
`default_nettype wire

FILE: hw/rtl/ccfd_out_reg.sv
`default_nettype none
`include "assert_macros.svh"
module ccfd_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            load,
  input  wire ccfd_pkg::res_t  d,
  input  wire logic            ready,
  output logic                 valid,
  output ccfd_pkg::res_t       q,
  output logic                 can_load
);

  logic           valid_r;
  ccfd_pkg::res_t q_r;

  assign can_load = !valid_r || ready;
  assign valid = valid_r;
  assign q = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= d;
    end
  end

  `ASSERT_NEVER(a_no_overwrite, load && !can_load, "result register overwritten before transfer")
  `ASSERT_CHK(a_status_only_end, (valid_r && !q_r.is_end) |-> (q_r.status == ccfd_pkg::ST_OK && q_r.plen == 8'd0), "payload transfer carries status fields")
  `ASSERT_NEVER(a_status_range, valid_r && q_r.status > ccfd_pkg::ST_TOO_LONG, "status code out of range")

endmodule
`default_nettype wire

FILE: hw/rtl/cobs_crc32_frame_decoder.sv
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    in_tdata[7:0] rx_byte
// out_      out  out_tvalid/out_tready  out_tlast is_frame_end, out_tdata payload/status/length
// cfg_      in   cfg_wr_en              cfg_wr_data[8:0] max_decoded_bytes
//
// one byte per cycle sustained unless out_tready stalls a result
// the cobs/crc step is a single pass between the input register and the result register
// reset (rst_n low, synchronous) clears frame state and sets the limit to 256
// a stalled result holds; bytes with no result pass, one with a result waits in in_byte_r
`default_nettype none
module cobs_crc32_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic             out_tlast,   // is_frame_end
  output logic [23:0]      out_tdata,   // [7:0] payload_byte, [10:8] frame_status,
                                        // [18:11] payload_length, [23:19] zero
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data
);

  logic           in_v_r;
  logic [7:0]     in_byte_r;
  logic [8:0]     max_r;
  logic [8:0]     lim;
  logic           has_res;
  logic           adv;
  logic           can_load;
  ccfd_pkg::res_t res;
  ccfd_pkg::res_t oq;

  assign lim = (max_r > ccfd_pkg::LIM_CAP) ? ccfd_pkg::LIM_CAP : max_r;

  // bytes with no result never wait on the output side
  assign adv = in_v_r && (!has_res || can_load);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= ccfd_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  ccfd_cobs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .byte_i  (in_byte_r),
    .lim_i   (lim),
    .has_res (has_res),
    .res     (res)
  );

  ccfd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv && has_res),
    .d        (res),
    .ready    (out_tready),
    .valid    (out_tvalid),
    .q        (oq),
    .can_load (can_load)
  );

  assign out_tlast = oq.is_end;
  assign out_tdata = {5'd0, oq.plen, oq.status, oq.pbyte};

endmodule
`default_nettype wire
